>>> src/b2nv_pkg.sv
// Shared types and constants of the BGRA to NV12 converter.
`default_nettype none

package b2nv_pkg;

  // Default limits of the frame geometry.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Widths of the register and result fields.
  localparam int SIZE_W  = 13;
  localparam int PLANE_W = 12;
  localparam int COMP_W  = 8;

  // Result queue geometry.
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // BT.601 limited-range coefficients, scaled by 256.
  localparam int LUMA_OFFSET   = 16 * 256;
  localparam int CHROMA_OFFSET = 128 * 256;
  localparam int Y_R  = 65;
  localparam int Y_G  = 129;
  localparam int Y_B  = 25;
  localparam int CB_R = 38;
  localparam int CB_G = 74;
  localparam int CB_B = 112;
  localparam int CR_R = 112;
  localparam int CR_G = 94;
  localparam int CR_B = 18;

  // One result item as it waits in the output queue.
  typedef struct packed {
    logic               is_chroma;
    logic [COMP_W-1:0]  luma;
    logic [COMP_W-1:0]  cb;
    logic [COMP_W-1:0]  cr;
    logic [PLANE_W-1:0] plane_row;
    logic [PLANE_W-1:0] plane_col;
    logic               last_of_item;
    logic               frame_end;
  } result_t;

endpackage

`default_nettype wire

>>> src/b2nv_result_fifo.sv
// Result queue taking up to two result items per cycle and giving one per cycle while the receiver is ready.
`default_nettype none

module b2nv_result_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_lo_i,
  input  logic                            push_hi_i,
  input  b2nv_pkg::result_t               data_lo_i,
  input  b2nv_pkg::result_t               data_hi_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output b2nv_pkg::result_t               head_o,
  output logic [b2nv_pkg::RES_CNT_W-1:0]  count_o
);

  localparam int PtrW = b2nv_pkg::RES_PTR_W;
  localparam int CntW = b2nv_pkg::RES_CNT_W;

  b2nv_pkg::result_t entry_q [b2nv_pkg::RES_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] push_n;
  logic            pop;

  always_comb begin
    push_n   = CntW'(push_lo_i) + CntW'(push_hi_i);
    pop      = valid_o && ready_i;
    wr_ptr_d = PtrW'(wr_ptr_q + PtrW'(push_n));
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + PtrW'(1)) : rd_ptr_q;
    cnt_d    = CntW'(cnt_q + push_n - CntW'(pop));
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // The second entry always follows the first one in the same cycle.
  always_ff @(posedge clk_i) begin
    if (push_lo_i) begin
      entry_q[wr_ptr_q] <= data_lo_i;
    end
    if (push_hi_i) begin
      entry_q[PtrW'(wr_ptr_q + PtrW'(1))] <= data_hi_i;
    end
  end

  a_hi_needs_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_hi_i |-> push_lo_i)
    else $error("second push without first push");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) + 32'(push_n)) <= b2nv_pkg::RES_DEPTH)
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q == PtrW'(rd_ptr_q + PtrW'(cnt_q)))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

>>> src/bgra_to_nv12_converter.sv
// BGRA to NV12 converter top level: pixel counters, luma, line store and chroma.
//
// Pixels enter on the s_axis channel in raster order, one item per pixel
// (blue, green and red; alpha is not carried). Every pixel gives a luma
// result item; a pixel at an odd row and an odd column also gives a chroma
// result item for its 2x2 block, straight after its luma item. Results leave
// on the m_axis channel with plane coordinates; tlast marks the last result
// of a frame. Frame width and height are set through the APB port, only while
// no item is in flight; the user must keep to this, the block does not enforce
// it. Results pass the second-stage registers and the result queue. The block
// takes one pixel per cycle while s_axis_tready is high; the output channel
// moves one result per cycle while m_axis_tready is high, so the output port
// sets the rate, at about 1.25 results per pixel for even geometry. Even-row
// pair sums wait in a single-port line store of MAX_WIDTH/2 entries with a
// registered read; each entry is written in the even row before the odd row
// reads it, so no forwarding is needed. Reset clears the counters, the held
// pixel and the result queue; the line store needs no clearing. When the
// receiver stalls, results collect in an eight-entry queue and s_axis_tready
// drops once five or more are waiting.

`default_nettype none

module bgra_to_nv12_converter #(
  parameter int MAX_WIDTH  = b2nv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = b2nv_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // luma [7:0], cb [15:8], cr [23:16],
                                      // plane_row [35:24], plane_col [47:36]
  output logic [1:0]  m_axis_tuser,   // is_chroma [0], last_of_item [1]
  output logic        m_axis_tlast,   // frame_end
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SizeW = b2nv_pkg::SIZE_W;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int IdxW  = (CW > 1) ? CW - 1 : 1;
  localparam int LsDepth = 2 ** IdxW;
  localparam int ExtW  = SizeW + 1;
  localparam int CntW  = b2nv_pkg::RES_CNT_W;

  // Register indexes, taken from paddr[2].
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SizeW-1:0] frame_width_q;
  logic [SizeW-1:0] frame_height_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= SizeW'(1920);
      frame_height_q <= SizeW'(1080);
    end else if (cfg_wr) begin
      if (paddr[2] == RegWidth) begin
        frame_width_q <= pwdata[SizeW-1:0];
      end
      if (paddr[2] == RegHeight) begin
        frame_height_q <= pwdata[SizeW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegHeight) ? 32'(frame_height_q) : 32'(frame_width_q);

  // Sizes of zero count as one; sizes above the limits count as the limit.
  logic [ExtW-1:0] width_eff, height_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = ExtW'(1);
    end else if (ExtW'(frame_width_q) > ExtW'(MAX_WIDTH)) begin
      width_eff = ExtW'(MAX_WIDTH);
    end else begin
      width_eff = ExtW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_eff = ExtW'(1);
    end else if (ExtW'(frame_height_q) > ExtW'(MAX_HEIGHT)) begin
      height_eff = ExtW'(MAX_HEIGHT);
    end else begin
      height_eff = ExtW'(frame_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: raster position, held pixel, luma and line store access
  // ---------------------------------------------------------------------------
  logic [7:0] pix_b, pix_g, pix_r;
  logic       accept;
  logic [CntW-1:0] fifo_cnt;

  assign pix_b = s_axis_tdata[7:0];
  assign pix_g = s_axis_tdata[15:8];
  assign pix_r = s_axis_tdata[23:16];

  // Room for the item in the second stage and for the new one, two each.
  assign s_axis_tready = (fifo_cnt <= CntW'(b2nv_pkg::RES_DEPTH - 4));
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [23:0]   held_q;
  logic          col_end, row_end;
  logic [8:0]    sum_b, sum_g, sum_r;
  logic [15:0]   luma_full;
  logic          want_chroma;

  always_comb begin
    col_end = (ExtW'(col_q) + ExtW'(1)) >= width_eff;
    row_end = (ExtW'(row_q) + ExtW'(1)) >= height_eff;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : RW'(row_q + RW'(1));
    end else begin
      col_d = CW'(col_q + CW'(1));
      row_d = row_q;
    end

    // Held pixel is packed as blue, green, red from the top byte down.
    sum_b = 9'(held_q[23:16]) + 9'(pix_b);
    sum_g = 9'(held_q[15:8])  + 9'(pix_g);
    sum_r = 9'(held_q[7:0])   + 9'(pix_r);

    luma_full = 16'(b2nv_pkg::LUMA_OFFSET)
              + 16'(b2nv_pkg::Y_R) * 16'(pix_r)
              + 16'(b2nv_pkg::Y_G) * 16'(pix_g)
              + 16'(b2nv_pkg::Y_B) * 16'(pix_b);

    want_chroma = col_q[0] && row_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      if (!col_q[0]) begin
        held_q <= {pix_b, pix_g, pix_r};
      end
    end
  end

  // Line store of even-row pair sums, blue in the top nine bits.
  logic [26:0]     line_mem [LsDepth];
  logic [26:0]     ls_rdata_q;
  logic [IdxW-1:0] ls_addr;
  logic            ls_we;

  assign ls_addr = IdxW'(col_q >> 1);
  assign ls_we   = accept && col_q[0] && !row_q[0];

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      line_mem[ls_addr] <= {sum_b, sum_g, sum_r};
    end
    ls_rdata_q <= line_mem[ls_addr];
  end

  // ---------------------------------------------------------------------------
  // Second stage: 2x2 average and chroma, then into the result queue
  // ---------------------------------------------------------------------------
  logic          s1_valid_q;
  logic          s1_chroma_q;
  logic          s1_frame_end_q;
  logic [7:0]    s1_luma_q;
  logic [26:0]   s1_sums_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_chroma_q    <= want_chroma;
      s1_frame_end_q <= col_end && row_end;
      s1_luma_q      <= luma_full[15:8];
      s1_sums_q      <= {sum_b, sum_g, sum_r};
      s1_col_q       <= col_q;
      s1_row_q       <= row_q;
    end
  end

  logic [9:0]  tot_b, tot_g, tot_r;
  logic [7:0]  avg_b, avg_g, avg_r;
  logic [15:0] cb_full, cr_full;
  b2nv_pkg::result_t res_luma, res_chroma;

  always_comb begin
    tot_b = 10'(ls_rdata_q[26:18]) + 10'(s1_sums_q[26:18]);
    tot_g = 10'(ls_rdata_q[17:9])  + 10'(s1_sums_q[17:9]);
    tot_r = 10'(ls_rdata_q[8:0])   + 10'(s1_sums_q[8:0]);
    avg_b = tot_b[9:2];
    avg_g = tot_g[9:2];
    avg_r = tot_r[9:2];

    // Both results stay positive, so the wrap of the 16-bit sums is harmless.
    cb_full = 16'(b2nv_pkg::CHROMA_OFFSET)
            + 16'(b2nv_pkg::CB_B) * 16'(avg_b)
            - 16'(b2nv_pkg::CB_R) * 16'(avg_r)
            - 16'(b2nv_pkg::CB_G) * 16'(avg_g);
    cr_full = 16'(b2nv_pkg::CHROMA_OFFSET)
            + 16'(b2nv_pkg::CR_R) * 16'(avg_r)
            - 16'(b2nv_pkg::CR_G) * 16'(avg_g)
            - 16'(b2nv_pkg::CR_B) * 16'(avg_b);

    res_luma.is_chroma    = 1'b0;
    res_luma.luma         = s1_luma_q;
    res_luma.cb           = '0;
    res_luma.cr           = '0;
    res_luma.plane_row    = b2nv_pkg::PLANE_W'(32'(s1_row_q));
    res_luma.plane_col    = b2nv_pkg::PLANE_W'(32'(s1_col_q));
    res_luma.last_of_item = !s1_chroma_q;
    res_luma.frame_end    = !s1_chroma_q && s1_frame_end_q;

    res_chroma.is_chroma    = 1'b1;
    res_chroma.luma         = '0;
    res_chroma.cb           = cb_full[15:8];
    res_chroma.cr           = cr_full[15:8];
    res_chroma.plane_row    = b2nv_pkg::PLANE_W'(32'(s1_row_q) >> 1);
    res_chroma.plane_col    = b2nv_pkg::PLANE_W'(32'(s1_col_q) >> 1);
    res_chroma.last_of_item = 1'b1;
    res_chroma.frame_end    = s1_frame_end_q;
  end

  b2nv_pkg::result_t head;

  b2nv_result_fifo u_result_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_lo_i (s1_valid_q),
    .push_hi_i (s1_valid_q && s1_chroma_q),
    .data_lo_i (res_luma),
    .data_hi_i (res_chroma),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .head_o    (head),
    .count_o   (fifo_cnt)
  );

  assign m_axis_tdata = {head.plane_col, head.plane_row, head.cr, head.cb, head.luma};
  assign m_axis_tuser = {head.last_of_item, head.is_chroma};
  assign m_axis_tlast = head.frame_end;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_chroma_odd_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_chroma_q) |-> (s1_col_q[0] && s1_row_q[0]))
    else $error("chroma item at an even row or column");

  a_accept_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (s1_valid_q && s1_col_q == $past(col_q) && s1_row_q == $past(row_q)))
    else $error("accepted pixel lost before the second stage");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && col_end && row_end) |=> (col_q == '0 && row_q == '0))
    else $error("raster position did not wrap at frame end");

endmodule

`default_nettype wire

>>> tb/bgra_to_nv12_converter_tb_pkg.sv
// Register map of the converter as seen by the testbench and its checker.
package bgra_to_nv12_converter_tb_pkg;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

endpackage

>>> tb/bgra_to_nv12_converter_checker.sv
// Checker of the converter: predicts every luma and chroma item and compares the output stream.
module bgra_to_nv12_converter_checker
  import b2nv_pkg::*;
  import bgra_to_nv12_converter_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatch_count,
  output int unsigned results_due
);

  result_t     awaited_results [$];
  logic [26:0] row_pair_sums [2048];
  logic [23:0] held_bgr;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  result_t     seen;
  result_t     want;

  function automatic int unsigned clamped_size(logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  task automatic compare_field(string label, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Works out the luma item and, at odd row and odd column, the chroma item of one pixel.
  task automatic predict_pixel(input logic [23:0] px);
    result_t     luma_res;
    result_t     chroma_res;
    logic        has_chroma;
    logic        frame_done;
    int          bv, gv, rv;
    int          sb, sg, sr;
    int          ab, ag, ar;
    int unsigned w, h, idx;
    logic [26:0] stored;

    bv = px[7:0];
    gv = px[15:8];
    rv = px[23:16];
    w = clamped_size(width_reg);
    h = clamped_size(height_reg);
    has_chroma = 1'b0;
    luma_res = '0;
    chroma_res = '0;
    luma_res.luma = 8'((4096 + 65 * rv + 129 * gv + 25 * bv) >>> 8);
    luma_res.plane_row = row_pos[11:0];
    luma_res.plane_col = col_pos[11:0];

    if (!col_pos[0]) begin
      held_bgr = px;
    end else begin
      sb = int'(held_bgr[7:0]) + bv;
      sg = int'(held_bgr[15:8]) + gv;
      sr = int'(held_bgr[23:16]) + rv;
      idx = (col_pos >> 1) & 2047;
      if (!row_pos[0]) begin
        row_pair_sums[idx] = {sb[8:0], sg[8:0], sr[8:0]};
      end else begin
        stored = row_pair_sums[idx];
        ab = (int'(stored[26:18]) + sb) >>> 2;
        ag = (int'(stored[17:9]) + sg) >>> 2;
        ar = (int'(stored[8:0]) + sr) >>> 2;
        chroma_res.is_chroma = 1'b1;
        chroma_res.cb = 8'((32768 - 38 * ar - 74 * ag + 112 * ab) >>> 8);
        chroma_res.cr = 8'((32768 + 112 * ar - 94 * ag - 18 * ab) >>> 8);
        chroma_res.plane_row = 12'(row_pos >> 1);
        chroma_res.plane_col = 12'(col_pos >> 1);
        has_chroma = 1'b1;
      end
    end

    frame_done = (col_pos + 1 >= w) && (row_pos + 1 >= h);
    if (has_chroma) begin
      chroma_res.last_of_item = 1'b1;
      chroma_res.frame_end = frame_done;
      awaited_results.push_back(luma_res);
      awaited_results.push_back(chroma_res);
    end else begin
      luma_res.last_of_item = 1'b1;
      luma_res.frame_end = frame_done;
      awaited_results.push_back(luma_res);
    end

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = frame_done ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      held_bgr = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = 13'd1920;
      height_reg = 13'd1080;
      mismatch_count = 0;
      results_due = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.is_chroma    = m_axis_tuser[0];
        seen.last_of_item = m_axis_tuser[1];
        seen.frame_end    = m_axis_tlast;
        seen.luma         = m_axis_tdata[7:0];
        seen.cb           = m_axis_tdata[15:8];
        seen.cr           = m_axis_tdata[23:16];
        seen.plane_row    = m_axis_tdata[35:24];
        seen.plane_col    = m_axis_tdata[47:36];
        if (awaited_results.size() == 0) begin
          $display("%0t: result item with nothing expected, expected none, actual %h/%b/%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("is_chroma", want.is_chroma, seen.is_chroma);
          compare_field("luma", want.luma, seen.luma);
          compare_field("cb", want.cb, seen.cb);
          compare_field("cr", want.cr, seen.cr);
          compare_field("plane_row", want.plane_row, seen.plane_row);
          compare_field("plane_col", want.plane_col, seen.plane_col);
          compare_field("last_of_item", want.last_of_item, seen.last_of_item);
          compare_field("frame_end", want.frame_end, seen.frame_end);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_FRAME_WIDTH:  width_reg = pwdata[12:0];
          REG_FRAME_HEIGHT: height_reg = pwdata[12:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixel(s_axis_tdata);
      end
      results_due = awaited_results.size();
    end
  end

endmodule

>>> tb/bgra_to_nv12_converter_tb.sv
// Testbench top of the BGRA to NV12 converter: clock, reset, stimulus and verdict.
module bgra_to_nv12_converter_tb;
  import bgra_to_nv12_converter_tb_pkg::*;

  // The run is bounded by a cycle count far above the slowest correct run:
  // about 470 pixels, up to two results each, with heavy idling on either side.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 150;

  // Directed pixels, packed as in tdata: red [23:16], green [15:8], blue [7:0].
  localparam logic [23:0] DIRECTED_PIXELS [21] = '{
    // Widest and tallest frame, cut short after six pixels of row 0.
    24'h0000FF, 24'h0000FF, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h808080,
    // After shrinking to 2x2: finishes row 0, then a pure blue 2x2 block.
    24'h000000, 24'h0000FF, 24'h0000FF,
    // Size registers at zero: every pixel is a frame of its own.
    24'hFFFFFF, 24'h000000, 24'h7F7F7F,
    // 3x3 frame: chroma only for the red block, none for the odd edges.
    24'hFF0000, 24'hFF0000, 24'h00FF00,
    24'hFF0000, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFFFF, 24'h000000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;     // blue [7:0], green [15:8], red [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;          // luma, cb, cr, plane_row, plane_col
  logic [1:0]  m_axis_tuser;          // is_chroma [0], last_of_item [1]
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatch_count;
  int unsigned results_due;
  int unsigned cycle_count = 0;
  int unsigned random_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 20;
  logic        hold_go = 1'b0;
  logic        hold_active = 1'b0;

  always #1 clk_i = ~clk_i;

  bgra_to_nv12_converter dut (.*);

  bgra_to_nv12_converter_checker checker_inst (.*);

  // Watchdog: a run that never drains ends here with a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls at random at the current rate, and on every cycle
  // of the long hold-off.
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
  end

  // The long hold-off keeps the output blocked long enough for the result
  // queue to fill and the block to refuse further pixels, while the sender
  // goes on offering them.
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_active <= 1'b0;
  end

  // One register write: setup cycle, then the access cycle until pready.
  // The task ends only after the bus is released, on a later falling edge, so
  // that the next write never raises psel in the step where it was lowered.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stops offering pixels and waits until every expected result has come.
  // Every pixel gives at least one result, so an empty queue of
  // expectations means the block is idle; the wait after it is a margin.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    drain_results();
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
  endtask

  // Offers one pixel, after random idle cycles, and waits for its handshake.
  // tvalid is not lowered between back-to-back pixels.
  task automatic send_pixel(input logic [23:0] px);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random pixels, with saturated components now and then so that the
  // chroma extremes keep turning up.
  task automatic send_random_pixels(input int unsigned count);
    logic [23:0] px;
    repeat (count) begin
      px = 24'($urandom);
      if ($urandom_range(7) == 0) begin
        px = {{8{px[0]}}, {8{px[1]}}, {8{px[2]}}};
      end
      send_pixel(px);
      random_sent++;
    end
  endtask

  // A whole frame of random size: mostly small, now and then wider ones.
  // Frames stay whole, so each odd row reads pair sums written just before.
  task automatic random_frame();
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    pick = $urandom_range(99);
    if (pick < 70) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
    end else if (pick < 95) begin
      w = $urandom_range(9, 32);
      h = $urandom_range(1, 4);
    end else begin
      w = $urandom_range(33, 80);
      h = $urandom_range(1, 2);
    end
    set_frame_size(w, h);
    send_random_pixels(w * h);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. The largest frame is opened and left after six
    // pixels; shrinking it to 2x2 makes the next pixel pass the new last
    // column, so the row wraps, and the following row closes the frame
    // with a chroma item built from the pair sums written before the
    // change. A height above the maximum is used as the maximum.
    set_frame_size(4096, 8191);
    for (int i = 0; i < 6; i++) send_pixel(DIRECTED_PIXELS[i]);
    set_frame_size(2, 2);
    for (int i = 6; i < 9; i++) send_pixel(DIRECTED_PIXELS[i]);
    // Sizes of zero are taken as one.
    set_frame_size(0, 0);
    for (int i = 9; i < 12; i++) send_pixel(DIRECTED_PIXELS[i]);
    // Odd width and height: the last column and row give no chroma.
    set_frame_size(3, 3);
    for (int i = 12; i < 21; i++) send_pixel(DIRECTED_PIXELS[i]);

    // Random part, first with a slow receiver, then with a slow sender.
    tx_idle_pct = 8;
    rx_idle_pct = 83;
    while (random_sent < PHASE_ITEMS) random_frame();
    tx_idle_pct = 83;
    rx_idle_pct = 8;
    while (random_sent < 2 * PHASE_ITEMS) random_frame();

    // Last phase runs at full rate on both sides; its first frame is long
    // enough to back up behind the long hold-off.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_frame_size(16, 4);
    hold_go <= 1'b1;
    send_random_pixels(64);
    while (random_sent < 3 * PHASE_ITEMS) random_frame();

    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> bgra_to_nv12_converter.f
src/b2nv_pkg.sv
src/b2nv_result_fifo.sv
src/bgra_to_nv12_converter.sv
tb/bgra_to_nv12_converter_tb_pkg.sv
tb/bgra_to_nv12_converter_checker.sv
tb/bgra_to_nv12_converter_tb.sv
